// File: hw/rtl/eds_pkg.sv
// Shared constants, types and tables for the EBML doctype sniffer.
`timescale 1ns / 1ps
package eds_pkg;

  localparam int WINDOW_BYTES = 512;
  localparam int SCAN_LIMIT   = 34;
  localparam int POS_W        = $clog2(WINDOW_BYTES + 1);
  localparam int LEN_W        = 56;

  localparam logic [7:0] ID_HIGH = 8'h42;
  localparam logic [7:0] ID_LOW  = 8'h82;

  localparam logic [2:0] ST_MATCH     = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
  localparam logic [2:0] ST_NO_ID     = 3'd2;
  localparam logic [2:0] ST_MISMATCH  = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;
  localparam logic [2:0] ST_UNDECIDED = 3'd7;

  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_SCAN,
    PH_SIZE_FIRST,
    PH_SIZE_REST,
    PH_STRING,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic       is_webm;
    logic [2:0] status;
    logic [5:0] offset;
  } verdict_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    case (idx)
      2'd0:    magic_byte = 8'h1a;
      2'd1:    magic_byte = 8'h45;
      2'd2:    magic_byte = 8'hdf;
      default: magic_byte = 8'ha3;
    endcase
  endfunction

  function automatic logic [7:0] name_byte(input logic [1:0] idx);
    case (idx)
      2'd0:    name_byte = 8'h77;  // w
      2'd1:    name_byte = 8'h65;  // e
      2'd2:    name_byte = 8'h62;  // b
      default: name_byte = 8'h6d;  // m
    endcase
  endfunction

endpackage

// File: hw/rtl/eds_core.sv
// Header parser state and per-byte next-state logic of the doctype sniffer.
`timescale 1ns / 1ps
module eds_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output eds_pkg::verdict_t   verdict
);

  localparam logic [eds_pkg::POS_W-1:0] POS_END  = eds_pkg::POS_W'(eds_pkg::WINDOW_BYTES);
  localparam logic [eds_pkg::POS_W-1:0] POS_SCAN = eds_pkg::POS_W'(eds_pkg::SCAN_LIMIT);

  logic [eds_pkg::POS_W-1:0] pos_r, pos_nxt;
  eds_pkg::phase_t           phase_r, phase_nxt;
  logic                      saw_id_r, saw_id_nxt;
  logic [2:0]                left_r, left_nxt;
  logic [eds_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [eds_pkg::POS_W-1:0] idx_r, idx_nxt;
  logic [2:0]                code_r, code_nxt;
  logic [5:0]                offset_r, offset_nxt;

  logic [eds_pkg::POS_W-1:0] pos_inc;
  logic [2:0]                first_left;
  logic [7:0]                first_len;
  logic [eds_pkg::LEN_W-1:0] rest_len;
  logic [7:0]                want;
  logic [eds_pkg::POS_W-1:0] idx_inc;
  logic [2:0]                status;

  assign pos_inc  = pos_r + 1'b1;
  assign idx_inc  = idx_r + 1'b1;
  assign rest_len = {len_r[eds_pkg::LEN_W-9:0], data_byte};
  assign want     = (idx_r < eds_pkg::POS_W'(4)) ? eds_pkg::name_byte(idx_r[1:0]) : 8'h00;

  // leading zeros of the first size byte; all-zero byte counts as eight bytes
  always_comb begin
    first_left = 3'd7;
    for (int i = 6; i >= 0; i--) begin
      if (data_byte[7-i]) first_left = 3'(i);
    end
    first_len = data_byte;
    first_len[3'd7 - first_left] = 1'b0;
  end

  always_comb begin
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    saw_id_nxt = saw_id_r;
    left_nxt   = left_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    code_nxt   = code_r;
    offset_nxt = offset_r;
    if (pos_r != POS_END) begin
      pos_nxt = pos_inc;
      case (phase_r)
        eds_pkg::PH_MAGIC: begin
          if (data_byte != eds_pkg::magic_byte(pos_r[1:0])) begin
            code_nxt  = eds_pkg::ST_BAD_MAGIC;
            phase_nxt = eds_pkg::PH_DONE;
          end else if (pos_r >= eds_pkg::POS_W'(3)) begin
            phase_nxt = eds_pkg::PH_SCAN;
          end
        end
        eds_pkg::PH_SCAN: begin
          if (saw_id_r && data_byte == eds_pkg::ID_LOW) begin
            saw_id_nxt = 1'b0;
            phase_nxt  = eds_pkg::PH_SIZE_FIRST;
          end else if (pos_r >= POS_SCAN) begin
            saw_id_nxt = 1'b0;
            code_nxt   = eds_pkg::ST_NO_ID;
            phase_nxt  = eds_pkg::PH_DONE;
          end else begin
            saw_id_nxt = (data_byte == eds_pkg::ID_HIGH);
          end
        end
        eds_pkg::PH_SIZE_FIRST: begin
          len_nxt  = eds_pkg::LEN_W'(first_len);
          left_nxt = first_left;
          if (first_left == 3'd0) begin
            offset_nxt = pos_inc[5:0];
            idx_nxt    = '0;
            if (first_len < 8'd4) begin
              code_nxt  = eds_pkg::ST_MISMATCH;
              phase_nxt = eds_pkg::PH_DONE;
            end else begin
              phase_nxt = eds_pkg::PH_STRING;
            end
          end else begin
            phase_nxt = eds_pkg::PH_SIZE_REST;
          end
        end
        eds_pkg::PH_SIZE_REST: begin
          len_nxt  = rest_len;
          left_nxt = left_r - 1'b1;
          if (left_r == 3'd1) begin
            offset_nxt = pos_inc[5:0];
            idx_nxt    = '0;
            if (rest_len < eds_pkg::LEN_W'(4)) begin
              code_nxt  = eds_pkg::ST_MISMATCH;
              phase_nxt = eds_pkg::PH_DONE;
            end else begin
              phase_nxt = eds_pkg::PH_STRING;
            end
          end
        end
        eds_pkg::PH_STRING: begin
          if (data_byte != want) begin
            code_nxt  = eds_pkg::ST_MISMATCH;
            phase_nxt = eds_pkg::PH_DONE;
          end else begin
            idx_nxt = idx_inc;
            if (eds_pkg::LEN_W'(idx_inc) >= len_r) begin
              code_nxt  = eds_pkg::ST_MATCH;
              phase_nxt = eds_pkg::PH_DONE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // verdict as seen after this byte; only used on the last byte
  always_comb begin
    case (phase_nxt)
      eds_pkg::PH_DONE: status = code_nxt;
      eds_pkg::PH_SCAN: status = eds_pkg::ST_NO_ID;
      default:          status = eds_pkg::ST_TRUNC;
    endcase
    verdict.is_webm = (status == eds_pkg::ST_MATCH);
    verdict.status  = status;
    verdict.offset  = (status == eds_pkg::ST_MATCH) ? offset_nxt : 6'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && last_byte)) begin
      pos_r    <= '0;
      phase_r  <= eds_pkg::PH_MAGIC;
      saw_id_r <= 1'b0;
      left_r   <= '0;
      len_r    <= '0;
      idx_r    <= '0;
      code_r   <= eds_pkg::ST_UNDECIDED;
      offset_r <= '0;
    end else if (take) begin
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      saw_id_r <= saw_id_nxt;
      left_r   <= left_nxt;
      len_r    <= len_nxt;
      idx_r    <= idx_nxt;
      code_r   <= code_nxt;
      offset_r <= offset_nxt;
    end
  end

endmodule

// File: hw/rtl/ebml_doctype_sniffer_top.sv
// Top level of the EBML doctype sniffer: input register, parser, verdict register.
`timescale 1ns / 1ps
// Flow: a last byte goes from the input register into the verdict register, and
//   out_valid rises once it loads; a verdict not yet taken holds the byte in between.
// Throughput: one byte per cycle; the input register drains every cycle unless a
//   last byte waits behind a verdict that has not been taken yet.
// Reset: synchronous, active-low rst_n empties both registers and puts the parser
//   back to checking the magic; the parser also returns there after every last byte.
module ebml_doctype_sniffer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_is_webm,
  output logic [2:0] out_status,
  output logic [5:0] out_str_offset
);

  // input stage
  logic       s1_valid_r;
  logic [7:0] s1_data_r;
  logic       s1_last_r;
  logic       s1_adv;

  // verdict stage
  logic              out_valid_r;
  eds_pkg::verdict_t out_r;
  eds_pkg::verdict_t verdict;

  // a plain byte always moves on; a last byte needs the verdict slot
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  eds_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (s1_adv),
    .data_byte (s1_data_r),
    .last_byte (s1_last_r),
    .verdict   (verdict)
  );

  // verdict register; loaded only by the last byte of a stream
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_r <= verdict;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_is_webm    = out_r.is_webm;
  assign out_status     = out_r.status;
  assign out_str_offset = out_r.offset;

endmodule

// File: hw/rtl/eds_checker.sv
// Port-level assertions for the EBML doctype sniffer and their bind.
`timescale 1ns / 1ps
module eds_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_is_webm,
  input logic [2:0] out_status,
  input logic [5:0] out_str_offset
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("verdict valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_is_webm) && $stable(out_str_offset))
    else $error("stalled verdict changed");

  a_flag_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_webm == (out_status == eds_pkg::ST_MATCH)))
    else $error("is_webm disagrees with status");

  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_webm |-> out_str_offset == 6'd0)
    else $error("offset set without a match");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= eds_pkg::ST_TRUNC)
    else $error("undecided or unknown status delivered");

endmodule

bind ebml_doctype_sniffer_top eds_checker u_eds_checker (.*);
